// ----- rtl/idwm_pkg.sv -----
`default_nettype none
package idwm_pkg;

  localparam int unsigned ADDR_W      = 4;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned QUEUE_DEPTH = 2;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_HALF_PERIOD = 2'd0;
  localparam logic [1:0] REG_ACK_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_DEVICE_ADDR = 2'd2;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd4;
  localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd250;
  localparam logic [7:0]  DEVICE_ADDR_RESET = 8'h78;

  // request codes
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_CMD  = 2'd1;
  localparam logic [1:0] REQ_DATA = 2'd2;

  // control byte sent after the address
  localparam logic [7:0] CTRL_CMD = 8'h00;
  localparam logic [7:0] CTRL_DAT = 8'h40;

  typedef struct packed {
    logic [15:0] half_period;
    logic [7:0]  ack_timeout;
    logic [7:0]  device_addr;
  } cfg_t;

  typedef struct packed {
    logic       start;
    logic       data_wr;
    logic [7:0] payload;
    logic       sda;
  } item_t;

  typedef struct packed {
    logic scl;
    logic sda;
    logic drv;
    logic busy;
    logic done;
    logic err;
  } res_t;

endpackage
`default_nettype wire

// ----- rtl/idwm_front.sv -----
`default_nettype none
module idwm_front #(
  parameter int unsigned DEPTH = idwm_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_stall,
  input  wire logic [1:0]      req_type,
  input  wire logic [7:0]      payload_byte,
  input  wire logic            sda_in,
  output logic                 q_valid,
  output idwm_pkg::item_t      q_item,
  input  wire logic            q_pop
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  idwm_pkg::item_t mem [DEPTH];
  idwm_pkg::item_t item;
  logic [IW-1:0]   wr_ptr;
  logic [IW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push;

  // type 3 is a plain tick
  always_comb begin
    item.start   = (req_type == idwm_pkg::REQ_CMD) || (req_type == idwm_pkg::REQ_DATA);
    item.data_wr = (req_type == idwm_pkg::REQ_DATA);
    item.payload = payload_byte;
    item.sda     = sda_in;
  end

  assign req_stall = (count == CW'(DEPTH));
  assign push      = req_valid && !req_stall;
  assign q_valid   = (count != '0);
  assign q_item    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == IW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/idwm_engine.sv -----
`default_nettype none
module idwm_engine (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire idwm_pkg::cfg_t  cfg,
  input  wire logic            q_valid,
  input  wire idwm_pkg::item_t q_item,
  output logic                 q_pop,
  output logic                 res_valid,
  input  wire logic            res_stall,
  output idwm_pkg::res_t       res
);

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_START_A  = 4'd1,
    PH_START_B  = 4'd2,
    PH_SETUP    = 4'd3,
    PH_BIT_LOW  = 4'd4,
    PH_BIT_HIGH = 4'd5,
    PH_ACK_LOW  = 4'd6,
    PH_ACK_HIGH = 4'd7,
    PH_ACK_WAIT = 4'd8,
    PH_ACK_TAIL = 4'd9,
    PH_STOP_A   = 4'd10,
    PH_STOP_B   = 4'd11,
    PH_ESTOP_A  = 4'd12,
    PH_ESTOP_B  = 4'd13
  } phase_t;

  phase_t      phase, phase_next, ph;
  logic [3:0]  bit_count, bit_count_next, bit_inc;
  logic [1:0]  byte_index, byte_index_next, byte_inc;
  logic [15:0] delay_count, delay_next, dly;
  logic [7:0]  ack_wait_count, ack_next;
  logic [7:0]  shift_byte, shift_next;
  logic [7:0]  held_payload, held_next;
  logic        is_data_write, data_next;
  logic        start, bitv, timed, elapsed;
  logic [16:0] dly_inc;
  logic [8:0]  ack_inc;
  idwm_pkg::res_t r;

  assign q_pop = q_valid && (!res_valid || !res_stall);

  always_comb begin
    start = q_item.start && (phase == PH_IDLE);
    ph    = start ? PH_START_A : phase;
    dly   = start ? '0 : delay_count;
    bitv  = start ? cfg.device_addr[7] : shift_byte[7];

    phase_next      = ph;
    delay_next      = dly;
    bit_count_next  = start ? '0 : bit_count;
    byte_index_next = start ? '0 : byte_index;
    ack_next        = start ? '0 : ack_wait_count;
    shift_next      = start ? cfg.device_addr : shift_byte;
    held_next       = start ? q_item.payload : held_payload;
    data_next       = start ? q_item.data_wr : is_data_write;

    dly_inc  = {1'b0, dly} + 17'd1;
    elapsed  = (dly_inc >= {1'b0, cfg.half_period});
    ack_inc  = {1'b0, ack_wait_count} + 9'd1;
    bit_inc  = bit_count + 4'd1;
    byte_inc = byte_index + 2'd1;
    timed    = 1'b1;

    r = '{scl: 1'b1, sda: 1'b1, drv: 1'b1, busy: 1'b1, done: 1'b0, err: 1'b0};

    case (ph)
      PH_IDLE: begin
        r.busy = 1'b0;
        timed  = 1'b0;
      end
      PH_START_A: begin
        if (elapsed) phase_next = PH_START_B;
      end
      PH_START_B: begin
        r.sda = 1'b0;
        if (elapsed) phase_next = PH_SETUP;
      end
      PH_SETUP: begin
        r.scl = 1'b0;
        r.sda = 1'b0;
        if (elapsed) phase_next = PH_BIT_LOW;
      end
      PH_BIT_LOW: begin
        r.scl = 1'b0;
        r.sda = bitv;
        if (elapsed) phase_next = PH_BIT_HIGH;
      end
      PH_BIT_HIGH: begin
        r.sda = bitv;
        if (elapsed) begin
          shift_next = {shift_byte[6:0], 1'b0};
          if (bit_inc >= 4'd8) begin
            bit_count_next = '0;
            phase_next     = PH_ACK_LOW;
          end else begin
            bit_count_next = bit_inc;
            phase_next     = PH_BIT_LOW;
          end
        end
      end
      PH_ACK_LOW: begin
        r.scl = 1'b0;
        r.drv = 1'b0;
        if (elapsed) phase_next = PH_ACK_HIGH;
      end
      PH_ACK_HIGH: begin
        r.drv = 1'b0;
        if (elapsed) begin
          ack_next   = '0;
          phase_next = PH_ACK_WAIT;
        end
      end
      PH_ACK_WAIT: begin
        // untimed: waits on the line, not on the delay counter
        r.drv = 1'b0;
        timed = 1'b0;
        if (!q_item.sda) begin
          ack_next   = '0;
          delay_next = '0;
          phase_next = PH_ACK_TAIL;
        end else if (ack_inc > {1'b0, cfg.ack_timeout}) begin
          ack_next   = '0;
          delay_next = '0;
          phase_next = PH_ESTOP_A;
        end else begin
          ack_next = ack_inc[7:0];
        end
      end
      PH_ACK_TAIL: begin
        r.scl = 1'b0;
        r.drv = 1'b0;
        if (elapsed) begin
          if (byte_index >= 2'd2) begin
            phase_next = PH_STOP_A;
          end else begin
            byte_index_next = byte_inc;
            if (byte_inc == 2'd1) begin
              shift_next = is_data_write ? idwm_pkg::CTRL_DAT : idwm_pkg::CTRL_CMD;
            end else begin
              shift_next = held_payload;
            end
            bit_count_next = '0;
            phase_next     = PH_BIT_LOW;
          end
        end
      end
      PH_STOP_A: begin
        r.scl = 1'b0;
        r.sda = 1'b0;
        if (elapsed) phase_next = PH_STOP_B;
      end
      PH_ESTOP_A: begin
        r.scl = 1'b0;
        r.sda = 1'b0;
        if (elapsed) phase_next = PH_ESTOP_B;
      end
      PH_STOP_B: begin
        r.sda = 1'b0;
        if (elapsed) begin
          r.done     = 1'b1;
          phase_next = PH_IDLE;
        end
      end
      PH_ESTOP_B: begin
        r.sda = 1'b0;
        if (elapsed) begin
          r.done     = 1'b1;
          r.err      = 1'b1;
          phase_next = PH_IDLE;
        end
      end
      default: begin
        r.busy     = 1'b0;
        timed      = 1'b0;
        delay_next = '0;
        phase_next = PH_IDLE;
      end
    endcase

    if (timed) begin
      delay_next = elapsed ? '0 : dly_inc[15:0];
    end
    // released line reads high
    if (!r.drv) r.sda = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      bit_count      <= '0;
      byte_index     <= '0;
      delay_count    <= '0;
      ack_wait_count <= '0;
      shift_byte     <= '0;
      held_payload   <= '0;
      is_data_write  <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      if (q_pop) begin
        phase          <= phase_next;
        bit_count      <= bit_count_next;
        byte_index     <= byte_index_next;
        delay_count    <= delay_next;
        ack_wait_count <= ack_next;
        shift_byte     <= shift_next;
        held_payload   <= held_next;
        is_data_write  <= data_next;
        res_valid      <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res <= r;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/i2c_display_write_master.sv -----
// Tick-driven I2C write master. Each accepted item is one bus tick and gives exactly one
// pin/status item, in order. A request item in the idle phase starts START, address byte,
// control byte (0x00 command, 0x40 data), payload byte and STOP; requests while busy are
// ignored. One item is taken per clock while req_stall is low; an item is written into the
// input queue, then the sequencer loads its result into the output register. The
// input queue holds QUEUE_DEPTH items, so req_stall rises only once res_stall has held
// the output back long enough to fill it. Registers at byte addresses 0 (half period),
// 4 (acknowledge timeout) and 8 (device address) are to be written by the user only while
// the block is idle; the block itself does not enforce this.
`default_nettype none
module i2c_display_write_master #(
  parameter int unsigned QUEUE_DEPTH = idwm_pkg::QUEUE_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [idwm_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [idwm_pkg::DATA_W-1:0]   pwdata,
  output logic      [idwm_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  input  wire logic                          req_valid,
  output logic                               req_stall,
  input  wire logic [1:0]                    req_type,
  input  wire logic [7:0]                    payload_byte,
  input  wire logic                          sda_in,
  output logic                               res_valid,
  input  wire logic                          res_stall,
  output logic                               scl_level,
  output logic                               sda_level,
  output logic                               sda_drive_enable,
  output logic                               busy_res,
  output logic                               done_res,
  output logic                               ack_error
);

  idwm_pkg::cfg_t  cfg;
  idwm_pkg::item_t q_item;
  idwm_pkg::res_t  res;
  logic            q_valid;
  logic            q_pop;
  logic [1:0]      reg_index;
  logic            wr_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period <= idwm_pkg::HALF_PERIOD_RESET;
      cfg.ack_timeout <= idwm_pkg::ACK_TIMEOUT_RESET;
      cfg.device_addr <= idwm_pkg::DEVICE_ADDR_RESET;
    end else if (wr_en) begin
      case (reg_index)
        idwm_pkg::REG_HALF_PERIOD: cfg.half_period <= pwdata[15:0];
        idwm_pkg::REG_ACK_TIMEOUT: cfg.ack_timeout <= pwdata[7:0];
        idwm_pkg::REG_DEVICE_ADDR: cfg.device_addr <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      idwm_pkg::REG_HALF_PERIOD: prdata = {16'd0, cfg.half_period};
      idwm_pkg::REG_ACK_TIMEOUT: prdata = {24'd0, cfg.ack_timeout};
      idwm_pkg::REG_DEVICE_ADDR: prdata = {24'd0, cfg.device_addr};
      default:                   prdata = '0;
    endcase
  end

  idwm_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .payload_byte (payload_byte),
    .sda_in       (sda_in),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  idwm_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  assign scl_level        = res.scl;
  assign sda_level        = res.sda;
  assign sda_drive_enable = res.drv;
  assign busy_res         = res.busy;
  assign done_res         = res.done;
  assign ack_error        = res.err;

endmodule
`default_nettype wire

// ----- rtl/idwm_checker.sv -----
`default_nettype none
module idwm_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic res_valid,
  input wire logic res_stall,
  input wire logic scl_level,
  input wire logic sda_level,
  input wire logic sda_drive_enable,
  input wire logic busy_res,
  input wire logic done_res,
  input wire logic ack_error
);

  // an error only ever comes with the end of a transaction
  a_err_with_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && ack_error |-> done_res && busy_res)
    else $error("ack_error without done");

  // idle bus: both lines high and driven
  a_idle_lines: assert property (@(posedge clk) disable iff (rst)
    res_valid && !busy_res |-> scl_level && sda_level && sda_drive_enable && !done_res)
    else $error("idle item with bus activity");

  // line released only for the acknowledge, and then reads high
  a_release_high: assert property (@(posedge clk) disable iff (rst)
    res_valid && !sda_drive_enable |-> sda_level && busy_res)
    else $error("released sda not high");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(scl_level) && $stable(sda_level)
      && $stable(sda_drive_enable) && $stable(busy_res) && $stable(done_res))
    else $error("stalled item changed");

endmodule

bind i2c_display_write_master idwm_checker u_idwm_checker (.*);
`default_nettype wire

// ----- verif/i2c_pin_checker.sv -----
`timescale 1ns / 1ps
module i2c_pin_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [idwm_pkg::ADDR_W-1:0] paddr,
  input  logic [idwm_pkg::DATA_W-1:0] pwdata,
  input  logic                        req_valid,
  input  logic                        req_stall,
  input  logic [1:0]                  req_type,
  input  logic [7:0]                  payload_byte,
  input  logic                        sda_in,
  input  logic                        res_valid,
  input  logic                        res_stall,
  input  logic                        scl_level,
  input  logic                        sda_level,
  input  logic                        sda_drive_enable,
  input  logic                        busy_res,
  input  logic                        done_res,
  input  logic                        ack_error,
  output int                          mismatches,
  output int                          pending,
  output logic                        engine_busy
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_START_A, ST_START_B, ST_SETUP, ST_BIT_LOW, ST_BIT_HIGH,
    ST_ACK_LOW, ST_ACK_HIGH, ST_ACK_WAIT, ST_ACK_TAIL,
    ST_STOP_A, ST_STOP_B, ST_ESTOP_A, ST_ESTOP_B
  } bus_phase_t;

  idwm_pkg::cfg_t  cfg;
  bus_phase_t      phase;
  logic [3:0]      bit_cnt;
  logic [1:0]      byte_idx;
  logic [15:0]     delay_cnt;
  logic [7:0]      ack_cnt;
  logic [7:0]      shreg;
  logic [7:0]      held;
  logic            data_wr;
  idwm_pkg::res_t  expected_pins[$];

  // one tick of a timed phase, true once the half period has run out
  function automatic logic half_period_done();
    logic [16:0] n;
    n = {1'b0, delay_cnt} + 17'd1;
    if (n >= {1'b0, cfg.half_period}) begin
      delay_cnt = '0;
      return 1'b1;
    end
    delay_cnt = n[15:0];
    return 1'b0;
  endfunction

  function automatic idwm_pkg::res_t next_pins(input logic [1:0] req, input logic [7:0] pay,
                                               input logic sda_i);
    idwm_pkg::res_t r;
    logic           msb;
    logic [8:0]     waited;
    r.scl = 1'b1; r.sda = 1'b1; r.drv = 1'b1; r.busy = 1'b1; r.done = 1'b0; r.err = 1'b0;
    msb = shreg[7];
    // the request tick is already the first tick of start
    if (phase == ST_IDLE && (req == idwm_pkg::REQ_CMD || req == idwm_pkg::REQ_DATA)) begin
      data_wr   = (req == idwm_pkg::REQ_DATA);
      held      = pay;
      byte_idx  = '0;
      bit_cnt   = '0;
      shreg     = cfg.device_addr;
      delay_cnt = '0;
      ack_cnt   = '0;
      phase     = ST_START_A;
    end
    case (phase)
      ST_IDLE: r.busy = 1'b0;
      ST_START_A: if (half_period_done()) phase = ST_START_B;
      ST_START_B: begin
        r.sda = 1'b0;
        if (half_period_done()) phase = ST_SETUP;
      end
      ST_SETUP: begin
        r.scl = 1'b0; r.sda = 1'b0;
        if (half_period_done()) phase = ST_BIT_LOW;
      end
      ST_BIT_LOW: begin
        r.scl = 1'b0; r.sda = msb;
        if (half_period_done()) phase = ST_BIT_HIGH;
      end
      ST_BIT_HIGH: begin
        r.sda = msb;
        if (half_period_done()) begin
          shreg   = shreg << 1;
          bit_cnt = bit_cnt + 4'd1;
          if (bit_cnt >= 4'd8) begin
            bit_cnt = '0;
            phase   = ST_ACK_LOW;
          end else begin
            phase = ST_BIT_LOW;
          end
        end
      end
      ST_ACK_LOW: begin
        r.scl = 1'b0; r.drv = 1'b0;
        if (half_period_done()) phase = ST_ACK_HIGH;
      end
      ST_ACK_HIGH: begin
        r.drv = 1'b0;
        if (half_period_done()) begin
          ack_cnt = '0;
          phase   = ST_ACK_WAIT;
        end
      end
      ST_ACK_WAIT: begin
        r.drv = 1'b0;
        if (!sda_i) begin
          ack_cnt   = '0;
          delay_cnt = '0;
          phase     = ST_ACK_TAIL;
        end else begin
          waited = {1'b0, ack_cnt} + 9'd1;
          if (waited > {1'b0, cfg.ack_timeout}) begin
            ack_cnt   = '0;
            delay_cnt = '0;
            phase     = ST_ESTOP_A;
          end else begin
            ack_cnt = waited[7:0];
          end
        end
      end
      ST_ACK_TAIL: begin
        r.scl = 1'b0; r.drv = 1'b0;
        if (half_period_done()) begin
          if (byte_idx >= 2'd2) begin
            phase = ST_STOP_A;
          end else begin
            byte_idx = byte_idx + 2'd1;
            if (byte_idx == 2'd1) shreg = data_wr ? idwm_pkg::CTRL_DAT : idwm_pkg::CTRL_CMD;
            else shreg = held;
            bit_cnt = '0;
            phase   = ST_BIT_LOW;
          end
        end
      end
      ST_STOP_A, ST_ESTOP_A: begin
        r.scl = 1'b0; r.sda = 1'b0;
        if (half_period_done()) phase = (phase == ST_STOP_A) ? ST_STOP_B : ST_ESTOP_B;
      end
      ST_STOP_B, ST_ESTOP_B: begin
        r.sda = 1'b0;
        if (half_period_done()) begin
          r.done = 1'b1;
          r.err  = (phase == ST_ESTOP_B);
          phase  = ST_IDLE;
        end
      end
      default: begin
        r.busy    = 1'b0;
        delay_cnt = '0;
        phase     = ST_IDLE;
      end
    endcase
    // released line reads back high
    if (!r.drv) r.sda = 1'b1;
    return r;
  endfunction

  task automatic check_pin(input string name, input logic want, input logic got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %b actual %b", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    idwm_pkg::res_t seen;
    idwm_pkg::res_t want;
    if (rst) begin
      cfg.half_period = idwm_pkg::HALF_PERIOD_RESET;
      cfg.ack_timeout = idwm_pkg::ACK_TIMEOUT_RESET;
      cfg.device_addr = idwm_pkg::DEVICE_ADDR_RESET;
      phase      = ST_IDLE;
      bit_cnt    = '0;
      byte_idx   = '0;
      delay_cnt  = '0;
      ack_cnt    = '0;
      shreg      = '0;
      held       = '0;
      data_wr    = 1'b0;
      mismatches = 0;
      expected_pins.delete();
      pending     <= 0;
      engine_busy <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[idwm_pkg::ADDR_W-1:2])
          idwm_pkg::REG_HALF_PERIOD: cfg.half_period = pwdata[15:0];
          idwm_pkg::REG_ACK_TIMEOUT: cfg.ack_timeout = pwdata[7:0];
          idwm_pkg::REG_DEVICE_ADDR: cfg.device_addr = pwdata[7:0];
          default: ;
        endcase
      end
      if (req_valid && !req_stall)
        expected_pins.push_back(next_pins(req_type, payload_byte, sda_in));
      if (res_valid && !res_stall) begin
        seen = {scl_level, sda_level, sda_drive_enable, busy_res, done_res, ack_error};
        if (expected_pins.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected item, expected none actual %b", $time, seen);
        end else begin
          want = expected_pins.pop_front();
          check_pin("scl_level", want.scl, seen.scl);
          check_pin("sda_level", want.sda, seen.sda);
          check_pin("sda_drive_enable", want.drv, seen.drv);
          check_pin("busy_res", want.busy, seen.busy);
          check_pin("done_res", want.done, seen.done);
          check_pin("ack_error", want.err, seen.err);
        end
      end
      pending     <= expected_pins.size();
      engine_busy <= (phase != ST_IDLE);
    end
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

  // request code with no meaning, taken as a plain tick
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [idwm_pkg::ADDR_W-1:0] paddr = '0;
  logic [idwm_pkg::DATA_W-1:0] pwdata = '0;
  logic [idwm_pkg::DATA_W-1:0] prdata;
  logic                        pready;
  logic                        req_valid = 1'b0;
  logic                        req_stall;
  logic [1:0]                  req_type = idwm_pkg::REQ_TICK;
  logic [7:0]                  payload_byte = '0;
  logic                        sda_in = 1'b0;
  logic                        res_valid;
  logic                        res_stall = 1'b0;
  logic                        scl_level, sda_level, sda_drive_enable, busy_res, done_res;
  logic                        ack_error;

  int   mismatches;
  int   pending;
  logic engine_busy;

  int tx_mode = 0;
  int rx_mode = 0;
  int long_hold_reqs = 0;
  int long_holds_served = 0;
  int stall_left = 0;

  i2c_display_write_master uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .req_valid(req_valid), .req_stall(req_stall),
    .req_type(req_type), .payload_byte(payload_byte), .sda_in(sda_in),
    .res_valid(res_valid), .res_stall(res_stall),
    .scl_level(scl_level), .sda_level(sda_level), .sda_drive_enable(sda_drive_enable),
    .busy_res(busy_res), .done_res(done_res), .ack_error(ack_error)
  );

  i2c_pin_checker pin_check (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .req_valid(req_valid), .req_stall(req_stall),
    .req_type(req_type), .payload_byte(payload_byte), .sda_in(sda_in),
    .res_valid(res_valid), .res_stall(res_stall),
    .scl_level(scl_level), .sda_level(sda_level), .sda_drive_enable(sda_drive_enable),
    .busy_res(busy_res), .done_res(done_res), .ack_error(ack_error),
    .mismatches(mismatches), .pending(pending), .engine_busy(engine_busy)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mode 0 never waits, 1 waits now and then, 2 waits on most items
  function automatic int draw_wait(input int mode);
    if (mode == 0) return 0;
    if (mode == 1) return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
    return $urandom_range(0, 17);
  endfunction

  // a missing acknowledge holds the line high, otherwise it is low with some noise
  function automatic logic line_level(input logic nack);
    return nack | ($urandom_range(0, 3) == 0);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
      res_stall <= 1'b0;
    end else begin
      if (stall_left > 0) stall_left--;
      else if (long_hold_reqs != long_holds_served) begin
        stall_left = 60;
        long_holds_served++;
      end else if (res_valid && !res_stall) stall_left = draw_wait(rx_mode);
      res_stall <= (stall_left > 0);
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [idwm_pkg::DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_item(input logic [1:0] r, input logic [7:0] p, input logic s);
    int gap;
    gap = draw_wait(tx_mode);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid    <= 1'b1;
    req_type     <= r;
    payload_byte <= p;
    sda_in       <= s;
    do @(posedge clk); while (req_stall);
  endtask

  // tick on with the acknowledge given until the bus engine is back in idle
  task automatic finish_transfer(input logic nack);
    do send_item(idwm_pkg::REQ_TICK, 8'($urandom), line_level(nack)); while (engine_busy);
  endtask

  task automatic drain_results();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic run_write(input logic [1:0] r, input logic [7:0] p, input logic nack,
                           input logic poke);
    send_item(r, p, nack);
    // a second request while busy must be dropped with its payload
    if (poke) send_item(idwm_pkg::REQ_CMD, ~p, nack);
    finish_transfer(nack);
  endtask

  task automatic random_phase(input int count, input logic allow_req);
    logic       nack;
    logic [1:0] r;
    nack = 1'b0;
    for (int k = 0; k < count; k++) begin
      r = idwm_pkg::REQ_TICK;
      if (allow_req && $urandom_range(0, 19) == 0) begin
        r    = 2'($urandom_range(1, 3));
        nack = ($urandom_range(0, 4) == 0);
      end
      send_item(r, 8'($urandom), line_level(nack));
    end
    finish_transfer(1'b0);
    drain_results();
  endtask

  initial begin
    logic [15:0] half;
    logic [7:0]  tmo;
    logic [7:0]  addr;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings: plain ticks, the unused request code, both writes,
    // a request while busy and a timed-out acknowledge
    send_item(idwm_pkg::REQ_TICK, 8'h00, 1'b0);
    send_item(REQ_UNUSED, 8'hFF, 1'b1);
    run_write(idwm_pkg::REQ_CMD, 8'h00, 1'b0, 1'b0);
    run_write(idwm_pkg::REQ_DATA, 8'hFF, 1'b0, 1'b1);
    run_write(idwm_pkg::REQ_CMD, 8'h80, 1'b1, 1'b0);
    run_write(idwm_pkg::REQ_DATA, 8'h3C, 1'b0, 1'b0);
    drain_results();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: begin half = 16'd1; tmo = 8'd1; addr = 8'h00; end
        1: begin half = 16'd2; tmo = 8'd255; addr = 8'hFF; end
        2: begin half = 16'hFFFF; tmo = 8'd128; addr = 8'hA5; end
        default: begin
          half = 16'($urandom_range(1, 4));
          case ($urandom_range(0, 2))
            0: tmo = 8'($urandom_range(1, 4));
            1: tmo = 8'($urandom_range(5, 40));
            default: tmo = 8'($urandom_range(200, 255));
          endcase
          addr = 8'($urandom);
        end
      endcase
      write_reg(idwm_pkg::REG_HALF_PERIOD, idwm_pkg::DATA_W'(half));
      write_reg(idwm_pkg::REG_ACK_TIMEOUT, idwm_pkg::DATA_W'(tmo));
      write_reg(idwm_pkg::REG_DEVICE_ADDR, idwm_pkg::DATA_W'(addr));
      // receiver holds off for a long stretch while items keep coming
      tx_mode <= (ph == 3 || ph == 6) ? 0 : ph % 3;
      rx_mode <= (ph + 1) % 3;
      if (ph == 3 || ph == 6) begin
        long_hold_reqs <= long_hold_reqs + 1;
      end
      // longest half period only sees idle ticks, so no transfer is started
      if (ph == 2) random_phase(20, 1'b0);
      else random_phase(45, 1'b1);
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule
